// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/blt_pkg.sv =====
// Shared constants and types of the bounded list table.
package blt_pkg;

    localparam int NUM_LISTS    = 16;
    localparam int MAX_CAPACITY = 32;

    localparam int SLOT_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int ELEM_DEPTH = NUM_LISTS * MAX_CAPACITY;
    localparam int ELEM_AW    = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;

    localparam int KIND_W   = 3;
    localparam int NUM_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int AMOUNT_W = 7;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 6;
    localparam int META_W   = 2 * COUNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_RESIZE = 3'd1,
        KIND_APPEND = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_DELETE = 3'd4,
        KIND_COUNT  = 3'd5,
        KIND_READ   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 4'd0,
        STS_BAD_SLOT     = 4'd1,
        STS_BAD_SIZE     = 4'd2,
        STS_EXISTS       = 4'd3,
        STS_NO_LIST      = 4'd4,
        STS_FULL         = 4'd5,
        STS_EMPTY        = 4'd6,
        STS_NOT_FOUND    = 4'd7,
        STS_BAD_NEW_SIZE = 4'd8,
        STS_NO_MEMORY    = 4'd9,
        STS_BAD_INDEX    = 4'd10
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_META,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DEL_DONE,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    // One word of the per-slot descriptor memory.
    typedef struct packed {
        logic [COUNT_W-1:0] cap;
        logic [COUNT_W-1:0] len;
    } meta_t;

endpackage

// ===== sv/blt_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module blt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/blt_ctrl.sv =====
// Command sequencer: descriptor read-modify-write, element search and shift, and element read.
module blt_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [blt_pkg::KIND_W-1:0]        kind,
    input  logic [blt_pkg::NUM_W-1:0]         list_number,
    input  logic signed [blt_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [blt_pkg::AMOUNT_W-1:0] size_amount,
    input  logic [blt_pkg::INDEX_W-1:0]       element_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [blt_pkg::STATUS_W-1:0]      status,
    output logic [blt_pkg::COUNT_W-1:0]       element_count,
    output logic signed [blt_pkg::VALUE_W-1:0]  read_value,
    output logic                              elem_we,
    output logic [blt_pkg::ELEM_AW-1:0]       elem_addr,
    output logic [blt_pkg::VALUE_W-1:0]       elem_wdata,
    input  logic [blt_pkg::VALUE_W-1:0]       elem_rdata,
    output logic                              meta_we,
    output logic [blt_pkg::SLOT_W-1:0]        meta_addr,
    output blt_pkg::meta_t                    meta_wdata,
    input  blt_pkg::meta_t                    meta_rdata
);

    localparam int AW   = blt_pkg::ELEM_AW;
    localparam int SW   = blt_pkg::SLOT_W;
    localparam int CW   = blt_pkg::COUNT_W;
    localparam int VW   = blt_pkg::VALUE_W;
    localparam int NL   = blt_pkg::NUM_LISTS;
    localparam int MAXC = blt_pkg::MAX_CAPACITY;

    localparam logic signed [7:0]      MAX_S    = 8'(MAXC);
    localparam logic [CW-1:0]          MAX_C    = CW'(MAXC);
    localparam logic [blt_pkg::NUM_W-1:0] NL_NUM = blt_pkg::NUM_W'(NL);

    function automatic logic [AW-1:0] elem_at(input logic [SW-1:0] slot,
                                              input logic [CW-1:0] pos);
        return AW'(slot) * AW'(MAXC) + AW'(pos);
    endfunction

    blt_pkg::state_t  state_reg, state_next;
    blt_pkg::status_t sts_reg, sts_next;

    logic [blt_pkg::KIND_W-1:0]         kind_reg;
    logic [SW-1:0]                      slot_reg;
    logic [VW-1:0]                      value_reg;
    logic signed [blt_pkg::AMOUNT_W-1:0] amount_reg;
    logic [blt_pkg::INDEX_W-1:0]        index_reg;

    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rd_reg, rd_next;
    logic [NL-1:0] exists_reg, exists_next;

    logic                         out_valid_reg;
    logic [blt_pkg::STATUS_W-1:0] out_status_reg;
    logic [CW-1:0]                out_count_reg;
    logic [VW-1:0]                out_value_reg;

    logic                in_fire;
    logic                out_load;
    logic                slot_ok;
    logic [SW-1:0]       slot_in;
    logic                ex_m;
    logic [CW-1:0]       len_m;
    logic [CW-1:0]       cap_m;
    logic signed [7:0]   amt_x;
    logic signed [7:0]   ncap;
    logic [CW-1:0]       shrink_len;
    logic [CW:0]         pos_p1;
    logic [CW:0]         pos_p2;
    logic                match;
    logic                kind_known;

    assign in_ready = (state_reg == blt_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == blt_pkg::S_FINISH) && (!out_valid_reg || out_ready);

    assign slot_ok = (list_number != '0) && (list_number <= NL_NUM);
    assign slot_in = SW'(list_number - blt_pkg::NUM_W'(1));

    // A slot never created reads as a descriptor of length and capacity zero.
    assign ex_m  = exists_reg[slot_reg];
    assign len_m = ex_m ? meta_rdata.len : '0;
    assign cap_m = ex_m ? meta_rdata.cap : '0;

    assign amt_x      = 8'(amount_reg);
    assign ncap       = $signed({2'b00, cap_m}) + amt_x;
    assign shrink_len = (len_m > CW'(ncap)) ? CW'(ncap) : len_m;

    assign pos_p1 = {1'b0, pos_reg} + (CW+1)'(1);
    assign pos_p2 = {1'b0, pos_reg} + (CW+1)'(2);
    assign match  = (elem_rdata == value_reg);

    assign kind_known = (kind_reg <= blt_pkg::KIND_READ);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = slot_ok ? blt_pkg::S_META : blt_pkg::S_FINISH;
                end
            end
            blt_pkg::S_META:
            begin
                state_next = blt_pkg::S_FINISH;
                if (kind_reg == blt_pkg::KIND_DELETE && len_m != '0)
                begin
                    state_next = blt_pkg::S_SEARCH_RD;
                end
                else if (kind_reg == blt_pkg::KIND_READ && CW'(index_reg) < len_m)
                begin
                    state_next = blt_pkg::S_READ_WAIT;
                end
            end
            blt_pkg::S_SEARCH_RD:
            begin
                state_next = blt_pkg::S_SEARCH_CMP;
            end
            blt_pkg::S_SEARCH_CMP:
            begin
                if (match)
                begin
                    state_next = (pos_p1 < {1'b0, len_reg}) ? blt_pkg::S_SHIFT_RD
                                                             : blt_pkg::S_DEL_DONE;
                end
                else
                begin
                    state_next = (pos_p1 < {1'b0, len_reg}) ? blt_pkg::S_SEARCH_RD
                                                             : blt_pkg::S_FINISH;
                end
            end
            blt_pkg::S_SHIFT_RD:
            begin
                state_next = blt_pkg::S_SHIFT_WR;
            end
            blt_pkg::S_SHIFT_WR:
            begin
                state_next = (pos_p2 < {1'b0, len_reg}) ? blt_pkg::S_SHIFT_RD
                                                         : blt_pkg::S_DEL_DONE;
            end
            blt_pkg::S_DEL_DONE:
            begin
                state_next = blt_pkg::S_FINISH;
            end
            blt_pkg::S_READ_WAIT:
            begin
                state_next = blt_pkg::S_FINISH;
            end
            blt_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = blt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = blt_pkg::S_IDLE;
            end
        endcase
    end

    // Memory requests and datapath updates.
    always_comb
    begin
        len_next    = len_reg;
        cap_next    = cap_reg;
        pos_next    = pos_reg;
        sts_next    = sts_reg;
        cnt_next    = cnt_reg;
        rd_next     = rd_reg;
        exists_next = exists_reg;
        elem_we     = 1'b0;
        elem_addr   = elem_at(slot_reg, pos_reg);
        elem_wdata  = value_reg;
        meta_we     = 1'b0;
        meta_addr   = slot_reg;
        meta_wdata  = '{cap: cap_reg, len: len_reg};

        unique case (state_reg)
            blt_pkg::S_IDLE:
            begin
                meta_addr = slot_in;
                sts_next  = blt_pkg::STS_BAD_SLOT;
                cnt_next  = '0;
                rd_next   = '0;
            end
            blt_pkg::S_META:
            begin
                len_next = len_m;
                cap_next = cap_m;
                cnt_next = len_m;
                pos_next = '0;
                sts_next = blt_pkg::STS_OK;
                if (kind_reg != blt_pkg::KIND_CREATE && kind_known && !ex_m)
                begin
                    sts_next = blt_pkg::STS_NO_LIST;
                end
                else
                begin
                    unique case (kind_reg)
                        blt_pkg::KIND_CREATE:
                        begin
                            if (amt_x < 8'sd1)
                            begin
                                sts_next = blt_pkg::STS_BAD_SIZE;
                            end
                            else if (ex_m)
                            begin
                                sts_next = blt_pkg::STS_EXISTS;
                            end
                            else if (amt_x > MAX_S)
                            begin
                                sts_next = blt_pkg::STS_NO_MEMORY;
                            end
                            else
                            begin
                                meta_we               = 1'b1;
                                meta_wdata            = '{cap: CW'(amt_x), len: '0};
                                exists_next[slot_reg] = 1'b1;
                                cnt_next              = '0;
                            end
                        end
                        blt_pkg::KIND_RESIZE:
                        begin
                            if (ncap < 8'sd1)
                            begin
                                sts_next = blt_pkg::STS_BAD_NEW_SIZE;
                            end
                            else if (ncap > MAX_S)
                            begin
                                sts_next = blt_pkg::STS_NO_MEMORY;
                            end
                            else
                            begin
                                meta_we    = 1'b1;
                                meta_wdata = '{cap: CW'(ncap), len: shrink_len};
                                cnt_next   = shrink_len;
                            end
                        end
                        blt_pkg::KIND_APPEND:
                        begin
                            if (len_m >= cap_m || len_m >= MAX_C)
                            begin
                                sts_next = blt_pkg::STS_FULL;
                            end
                            else
                            begin
                                elem_we    = 1'b1;
                                elem_addr  = elem_at(slot_reg, len_m);
                                meta_we    = 1'b1;
                                meta_wdata = '{cap: cap_m, len: len_m + CW'(1)};
                                cnt_next   = len_m + CW'(1);
                            end
                        end
                        blt_pkg::KIND_REMOVE:
                        begin
                            if (len_m == '0)
                            begin
                                sts_next = blt_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                meta_we    = 1'b1;
                                meta_wdata = '{cap: cap_m, len: len_m - CW'(1)};
                                cnt_next   = len_m - CW'(1);
                            end
                        end
                        blt_pkg::KIND_DELETE,
                        blt_pkg::KIND_COUNT:
                        begin
                            if (len_m == '0)
                            begin
                                sts_next = blt_pkg::STS_EMPTY;
                            end
                        end
                        blt_pkg::KIND_READ:
                        begin
                            if (CW'(index_reg) >= len_m)
                            begin
                                sts_next = blt_pkg::STS_BAD_INDEX;
                            end
                            else
                            begin
                                elem_addr = elem_at(slot_reg, CW'(index_reg));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            blt_pkg::S_SEARCH_RD:
            begin
            end
            blt_pkg::S_SEARCH_CMP:
            begin
                if (!match)
                begin
                    if (pos_p1 < {1'b0, len_reg})
                    begin
                        pos_next = CW'(pos_p1);
                    end
                    else
                    begin
                        sts_next = blt_pkg::STS_NOT_FOUND;
                    end
                end
            end
            blt_pkg::S_SHIFT_RD:
            begin
                elem_addr = elem_at(slot_reg, CW'(pos_p1));
            end
            blt_pkg::S_SHIFT_WR:
            begin
                // entry pos+1 was read last cycle; move it down one place
                elem_we    = 1'b1;
                elem_wdata = elem_rdata;
                pos_next   = CW'(pos_p1);
            end
            blt_pkg::S_DEL_DONE:
            begin
                meta_we    = 1'b1;
                meta_wdata = '{cap: cap_reg, len: len_reg - CW'(1)};
                cnt_next   = len_reg - CW'(1);
            end
            blt_pkg::S_READ_WAIT:
            begin
                rd_next = elem_rdata;
            end
            blt_pkg::S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blt_pkg::S_IDLE;
            exists_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            exists_reg <= exists_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= kind;
            slot_reg   <= slot_in;
            value_reg  <= item_value;
            amount_reg <= size_amount;
            index_reg  <= element_index;
        end
        len_reg <= len_next;
        cap_reg <= cap_next;
        pos_reg <= pos_next;
        sts_reg <= sts_next;
        cnt_reg <= cnt_next;
        rd_reg  <= rd_next;
        if (out_load)
        begin
            out_status_reg <= sts_reg;
            out_count_reg  <= cnt_reg;
            out_value_reg  <= rd_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign element_count = out_count_reg;
    assign read_value    = out_value_reg;

endmodule

// ===== sv/bounded_list_table_top.sv =====
// Top level of the bounded list table: sequencer plus element and descriptor memories.
// A table of NUM_LISTS slots, each holding one list of signed 32-bit values with a
// capacity of 1 to MAX_CAPACITY, stored in a single-port element memory of
// NUM_LISTS*MAX_CAPACITY words; slot lengths and capacities live in a small
// descriptor memory, with one flip-flop per slot marking a created list. One command
// is handled at a time and gives one result. A successful read passes through an extra
// wait state for the element memory. Delete scans the list with a read and a compare
// state per entry and then moves each later entry down with a read and a write state
// per entry, all through the one port of the element memory. A new command is taken
// while the previous result still waits on the output register. No clearing pass is
// needed after reset.
`include "assert_macros.svh"

module bounded_list_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [blt_pkg::KIND_W-1:0]          kind,
    input  logic [blt_pkg::NUM_W-1:0]           list_number,
    input  logic signed [blt_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [blt_pkg::AMOUNT_W-1:0] size_amount,
    input  logic [blt_pkg::INDEX_W-1:0]         element_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [blt_pkg::STATUS_W-1:0]        status,
    output logic [blt_pkg::COUNT_W-1:0]         element_count,
    output logic signed [blt_pkg::VALUE_W-1:0]  read_value
);

    localparam logic [blt_pkg::COUNT_W-1:0] MAX_COUNT =
        blt_pkg::COUNT_W'(blt_pkg::MAX_CAPACITY);

    logic                           elem_we;
    logic [blt_pkg::ELEM_AW-1:0]    elem_addr;
    logic [blt_pkg::VALUE_W-1:0]    elem_wdata;
    logic [blt_pkg::VALUE_W-1:0]    elem_rdata;
    logic                           meta_we;
    logic [blt_pkg::SLOT_W-1:0]     meta_addr;
    blt_pkg::meta_t                 meta_wdata;
    blt_pkg::meta_t                 meta_rdata;
    logic [blt_pkg::META_W-1:0]     meta_rword;

    assign meta_rdata = blt_pkg::meta_t'(meta_rword);

    blt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .list_number   (list_number),
        .item_value    (item_value),
        .size_amount   (size_amount),
        .element_index (element_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .element_count (element_count),
        .read_value    (read_value),
        .elem_we       (elem_we),
        .elem_addr     (elem_addr),
        .elem_wdata    (elem_wdata),
        .elem_rdata    (elem_rdata),
        .meta_we       (meta_we),
        .meta_addr     (meta_addr),
        .meta_wdata    (meta_wdata),
        .meta_rdata    (meta_rdata)
    );

    blt_ram #(
        .WIDTH (blt_pkg::VALUE_W),
        .DEPTH (blt_pkg::ELEM_DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .addr  (elem_addr),
        .wdata (elem_wdata),
        .rdata (elem_rdata)
    );

    blt_ram #(
        .WIDTH (blt_pkg::META_W),
        .DEPTH (blt_pkg::NUM_LISTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .addr  (meta_addr),
        .wdata (meta_wdata),
        .rdata (meta_rword)
    );

    // memories are written only while a command is in flight
    `BLT_ASSERT_IMP(a_elem_wr_busy, elem_we, !in_ready)
    // a descriptor write is always followed by the result cycle, never by idle
    `BLT_ASSERT_NXT(a_meta_wr_then_busy, meta_we, !in_ready)
    `BLT_ASSERT_IMP(a_count_bound, out_valid, element_count <= MAX_COUNT)
    `BLT_ASSERT_IMP(a_read_only_ok, out_valid && read_value != '0, status == blt_pkg::STS_OK)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded list table: directed, random, streaming and stall tests.
module testbench;
    import blt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 2 * MAX_CAPACITY + 8;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   value;
    } outcome_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [KIND_W-1:0]          kind;
    logic [NUM_W-1:0]           list_number;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [AMOUNT_W-1:0] size_amount;
    logic [INDEX_W-1:0]         element_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         element_count;
    logic signed [VALUE_W-1:0]  read_value;

    // Mirror of the table contents
    logic [VALUE_W-1:0] slot_values [NUM_LISTS][MAX_CAPACITY];
    int                 slot_len    [NUM_LISTS];
    int                 slot_cap    [NUM_LISTS];
    bit                 slot_live   [NUM_LISTS];

    outcome_t pending_outcomes[$];
    int       mismatch_count   = 0;
    int       quiet_cycles     = 0;
    int       hold_off_request = 0;
    bit       no_idle          = 1'b0;

    bounded_list_table_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .list_number   (list_number),
        .item_value    (item_value),
        .size_amount   (size_amount),
        .element_index (element_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .element_count (element_count),
        .read_value    (read_value)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Applies one command to the mirror and returns the result it should produce.
    function automatic outcome_t predict_list_op(
        input logic [KIND_W-1:0]          op,
        input logic [NUM_W-1:0]           num,
        input logic signed [VALUE_W-1:0]  val,
        input logic signed [AMOUNT_W-1:0] amt,
        input logic [INDEX_W-1:0]         idx
    );
        outcome_t r;
        int       slot;
        int       len;
        int       new_cap;
        int       pos;
        r.status = STS_OK;
        r.count  = '0;
        r.value  = '0;
        if (num == 0 || num > NUM_LISTS)
        begin
            r.status = STS_BAD_SLOT;
            return r;
        end
        slot = int'(num) - 1;
        len  = slot_len[slot];
        if (op == KIND_CREATE)
        begin
            // size check, then existence, then the memory limit
            if (amt < 1)
                r.status = STS_BAD_SIZE;
            else if (slot_live[slot])
                r.status = STS_EXISTS;
            else if (amt > MAX_CAPACITY)
                r.status = STS_NO_MEMORY;
            else
            begin
                slot_live[slot] = 1'b1;
                slot_cap[slot]  = int'(amt);
                slot_len[slot]  = 0;
            end
        end
        else if (op != KIND_UNUSED && !slot_live[slot])
            r.status = STS_NO_LIST;
        else
        begin
            case (op)
                KIND_RESIZE:
                begin
                    new_cap = slot_cap[slot] + int'(amt);
                    if (new_cap < 1)
                        r.status = STS_BAD_NEW_SIZE;
                    else if (new_cap > MAX_CAPACITY)
                        r.status = STS_NO_MEMORY;
                    else
                    begin
                        slot_cap[slot] = new_cap;
                        if (len > new_cap)
                            slot_len[slot] = new_cap;
                    end
                end
                KIND_APPEND:
                begin
                    if (len >= slot_cap[slot])
                        r.status = STS_FULL;
                    else
                    begin
                        slot_values[slot][len] = val;
                        slot_len[slot] = len + 1;
                    end
                end
                KIND_REMOVE:
                begin
                    if (len == 0)
                        r.status = STS_EMPTY;
                    else
                        slot_len[slot] = len - 1;
                end
                KIND_DELETE:
                begin
                    if (len == 0)
                        r.status = STS_EMPTY;
                    else
                    begin
                        pos = 0;
                        while (pos < len && slot_values[slot][pos] !== val)
                            pos++;
                        if (pos == len)
                            r.status = STS_NOT_FOUND;
                        else
                        begin
                            for (int k = pos; k + 1 < len; k++)
                                slot_values[slot][k] = slot_values[slot][k + 1];
                            slot_len[slot] = len - 1;
                        end
                    end
                end
                KIND_COUNT:
                begin
                    if (len == 0)
                        r.status = STS_EMPTY;
                end
                KIND_READ:
                begin
                    if (int'(idx) >= len)
                        r.status = STS_BAD_INDEX;
                    else
                        r.value = slot_values[slot][idx];
                end
                default: ;
            endcase
        end
        r.count = slot_live[slot] ? COUNT_W'(slot_len[slot]) : '0;
        return r;
    endfunction

    // Offers one command and records its expected result once the transfer happens.
    // Valid is left high afterwards so a back-to-back command needs no toggle.
    task automatic issue_command(
        input logic [KIND_W-1:0]          op,
        input logic [NUM_W-1:0]           num,
        input logic signed [VALUE_W-1:0]  val,
        input logic signed [AMOUNT_W-1:0] amt,
        input logic [INDEX_W-1:0]         idx
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= op;
        list_number   <= num;
        item_value    <= val;
        size_amount   <= amt;
        element_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        pending_outcomes.push_back(predict_list_op(op, num, val, amt, idx));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed traffic on a few busy slots, with some bad slots and odd sizes.
    task automatic issue_random_command();
        logic [KIND_W-1:0]          op;
        logic [NUM_W-1:0]           num;
        logic signed [VALUE_W-1:0]  val;
        logic signed [AMOUNT_W-1:0] amt;
        logic [INDEX_W-1:0]         idx;
        int                         slot;
        int                         len;
        int                         roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            num = NUM_W'($urandom);
        else if (roll < 60)
            num = NUM_W'($urandom_range(1, 4));
        else
            num = NUM_W'($urandom_range(1, NUM_LISTS));
        slot = (num >= 1 && num <= NUM_LISTS) ? int'(num) - 1 : 0;
        len  = slot_len[slot];

        roll = $urandom_range(0, 99);
        if (roll < 8)
            op = KIND_CREATE;
        else if (roll < 18)
            op = KIND_RESIZE;
        else if (roll < 52)
            op = KIND_APPEND;
        else if (roll < 60)
            op = KIND_REMOVE;
        else if (roll < 72)
            op = KIND_DELETE;
        else if (roll < 78)
            op = KIND_COUNT;
        else if (roll < 98)
            op = KIND_READ;
        else
            op = KIND_UNUSED;

        // small value pool so duplicates and matches are common
        roll = $urandom_range(0, 99);
        if (op == KIND_DELETE && len > 0 && roll < 75)
            val = slot_values[slot][$urandom_range(0, len - 1)];
        else if (roll < 85)
            val = VALUE_W'($urandom_range(0, 7)) - 32'd4;
        else
            val = $urandom;

        roll = $urandom_range(0, 99);
        if (op == KIND_CREATE && roll < 70)
            amt = AMOUNT_W'($urandom_range(1, 8));
        else if (op == KIND_CREATE && roll < 90)
            amt = AMOUNT_W'($urandom_range(9, MAX_CAPACITY));
        else if (op == KIND_RESIZE && roll < 80)
            amt = AMOUNT_W'($urandom_range(0, 12)) - 7'd6;
        else
            amt = AMOUNT_W'($urandom);

        roll = $urandom_range(0, 99);
        if (op == KIND_READ && len > 0 && roll < 80)
            idx = INDEX_W'($urandom_range(0, len - 1));
        else
            idx = INDEX_W'($urandom);

        issue_command(op, num, val, amt, idx);
    endtask

    task automatic test_slot_and_kind_errors();
        issue_command(KIND_COUNT, 6'd0, '0, '0, '0);
        issue_command(KIND_APPEND, 6'd63, 32'sh7fff_ffff, '0, '0);
        issue_command(KIND_READ, NUM_W'(NUM_LISTS + 1), '0, '0, 5'd31);
        issue_command(KIND_UNUSED, 6'd0, '0, '0, '0);
        // every command but create on a slot with no list
        issue_command(KIND_RESIZE, 6'd2, '0, 7'sd1, '0);
        issue_command(KIND_APPEND, 6'd2, 32'sd5, '0, '0);
        issue_command(KIND_REMOVE, 6'd2, '0, '0, '0);
        issue_command(KIND_DELETE, 6'd2, 32'sd5, '0, '0);
        issue_command(KIND_COUNT, 6'd2, '0, '0, '0);
        issue_command(KIND_READ, 6'd2, '0, '0, '0);
        issue_command(KIND_UNUSED, 6'd2, 32'hffff_ffff, 7'h7f, 5'h1f);
        issue_command(KIND_CREATE, 6'd3, '0, 7'sd0, '0);
        issue_command(KIND_CREATE, 6'd3, '0, -7'sd32, '0);
        issue_command(KIND_CREATE, 6'd3, '0, -7'sd64, '0);
        issue_command(KIND_CREATE, 6'd3, '0, 7'sd33, '0);
        issue_command(KIND_CREATE, 6'd3, '0, 7'sd63, '0);
        wait_results_drained();
    endtask

    task automatic test_single_entry_list();
        issue_command(KIND_CREATE, 6'd1, '0, 7'sd1, '0);
        issue_command(KIND_CREATE, 6'd1, '0, 7'sd40, '0);
        issue_command(KIND_CREATE, 6'd1, '0, 7'sd0, '0);
        issue_command(KIND_APPEND, 6'd1, 32'sh8000_0000, '0, '0);
        issue_command(KIND_APPEND, 6'd1, 32'sd9, '0, '0);
        issue_command(KIND_READ, 6'd1, '0, '0, 5'd0);
        issue_command(KIND_READ, 6'd1, '0, '0, 5'd1);
        issue_command(KIND_READ, 6'd1, '0, '0, 5'd31);
        issue_command(KIND_COUNT, 6'd1, '0, '0, '0);
        issue_command(KIND_DELETE, 6'd1, 32'sd5, '0, '0);
        issue_command(KIND_DELETE, 6'd1, 32'sh8000_0000, '0, '0);
        issue_command(KIND_DELETE, 6'd1, 32'sd5, '0, '0);
        issue_command(KIND_REMOVE, 6'd1, '0, '0, '0);
        issue_command(KIND_COUNT, 6'd1, '0, '0, '0);
        issue_command(KIND_APPEND, 6'd1, 32'sh7fff_ffff, '0, '0);
        issue_command(KIND_REMOVE, 6'd1, '0, '0, '0);
        issue_command(KIND_RESIZE, 6'd1, '0, -7'sd1, '0);
        issue_command(KIND_RESIZE, 6'd1, '0, 7'sd31, '0);
        issue_command(KIND_RESIZE, 6'd1, '0, 7'sd1, '0);
        issue_command(KIND_RESIZE, 6'd1, '0, 7'sd0, '0);
        issue_command(KIND_RESIZE, 6'd1, '0, -7'sd31, '0);
        wait_results_drained();
    endtask

    // Largest list: longest scans and shifts, shrink with truncation.
    task automatic test_full_capacity();
        logic [VALUE_W-1:0] fill [MAX_CAPACITY];
        for (int k = 0; k < MAX_CAPACITY; k++)
            fill[k] = $urandom;
        fill[0]                = 32'h8000_0000;
        fill[MAX_CAPACITY - 1] = 32'h7fff_ffff;
        fill[3]                = 32'd1;
        fill[MAX_CAPACITY - 5] = 32'd1;
        issue_command(KIND_CREATE, NUM_W'(NUM_LISTS), '0, AMOUNT_W'(MAX_CAPACITY), '0);
        for (int k = 0; k < MAX_CAPACITY; k++)
            issue_command(KIND_APPEND, NUM_W'(NUM_LISTS), fill[k], '0, '0);
        issue_command(KIND_APPEND, NUM_W'(NUM_LISTS), 32'sd0, '0, '0);
        issue_command(KIND_READ, NUM_W'(NUM_LISTS), '0, '0, 5'd31);
        issue_command(KIND_DELETE, NUM_W'(NUM_LISTS), fill[MAX_CAPACITY - 1], '0, '0);
        issue_command(KIND_DELETE, NUM_W'(NUM_LISTS), fill[0], '0, '0);
        issue_command(KIND_DELETE, NUM_W'(NUM_LISTS), 32'sd1, '0, '0);
        issue_command(KIND_READ, NUM_W'(NUM_LISTS), '0, '0, 5'd2);
        issue_command(KIND_RESIZE, NUM_W'(NUM_LISTS), '0, 7'sd1, '0);
        issue_command(KIND_RESIZE, NUM_W'(NUM_LISTS), '0, -7'sd32, '0);
        issue_command(KIND_RESIZE, NUM_W'(NUM_LISTS), '0, -7'sd20, '0);
        issue_command(KIND_COUNT, NUM_W'(NUM_LISTS), '0, '0, '0);
        issue_command(KIND_RESIZE, NUM_W'(NUM_LISTS), '0, 7'sd20, '0);
        issue_command(KIND_READ, NUM_W'(NUM_LISTS), '0, '0, 5'd11);
        issue_command(KIND_READ, NUM_W'(NUM_LISTS), '0, '0, 5'd12);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) issue_random_command();
        wait_results_drained();
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        repeat (80) issue_random_command();
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    // Receiver stalls for a long stretch while commands keep coming back to back.
    task automatic test_output_hold_off();
        hold_off_request = HOLD_OFF_CYCLES;
        no_idle = 1'b1;
        repeat (30) issue_random_command();
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = '0;
        list_number   = '0;
        item_value    = '0;
        size_amount   = '0;
        element_index = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_slot_and_kind_errors();
        test_single_entry_list();
        test_full_capacity();
        test_random_traffic(560);
        test_streaming();
        test_output_hold_off();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stall before each transfer, or a long one on request.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_request > 0)
            begin
                stall = hold_off_request;
                hold_off_request = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with none pending: status %0d count %0d value %h",
                         $time, status, element_count, read_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (element_count !== want.count)
                begin
                    $display("%0t: element_count expected %0d, actual %0d",
                             $time, want.count, element_count);
                    mismatch_count++;
                end
                if (read_value !== want.value)
                begin
                    $display("%0t: read_value expected %h, actual %h",
                             $time, want.value, read_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a hung run: too many cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/blt_pkg.sv
sv/blt_ram.sv
sv/blt_ctrl.sv
sv/bounded_list_table_top.sv
tb/sv/testbench.sv
